>>> src/cpr_pkg.sv
package cpr_pkg;

    // Field geometry of the stream transactions
    localparam int VEC_W     = 63;
    localparam int SCL_W     = 21;
    localparam int IM_W      = 16;
    localparam int IM_FRAC   = 12;

    localparam int LANE_BITS_DEF = 21;
    localparam int FRAC_BITS_DEF = 10;

    localparam int NUM_LANES = 3;

    // Slave-side tdata layout, lowest bit first
    localparam int S_POS_A_LSB = 0;
    localparam int S_POS_B_LSB = S_POS_A_LSB + VEC_W;
    localparam int S_VEL_A_LSB = S_POS_B_LSB + VEC_W;
    localparam int S_VEL_B_LSB = S_VEL_A_LSB + VEC_W;
    localparam int S_NORM_LSB  = S_VEL_B_LSB + VEC_W;
    localparam int S_IMA_LSB   = S_NORM_LSB + VEC_W;
    localparam int S_IMB_LSB   = S_IMA_LSB + IM_W;
    localparam int S_CS_LSB    = S_IMB_LSB + IM_W;
    localparam int S_PEN_LSB   = S_CS_LSB + SCL_W;
    localparam int S_USED_W    = S_PEN_LSB + SCL_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Master-side tdata layout
    localparam int M_USED_W    = 4 * VEC_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    // Result payload held in the output buffer
    typedef struct packed {
        logic             sat;
        logic [VEC_W-1:0] vel_b;
        logic [VEC_W-1:0] vel_a;
        logic [VEC_W-1:0] pos_b;
        logic [VEC_W-1:0] pos_a;
    } t_result;

endpackage

>>> src/cpr_div.sv
module cpr_div #(
    parameter int NW = 58,
    parameter int DW = 27,
    parameter int QB = 31
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    // Restoring division, one quotient bit per stage
    logic [DW-1:0] r_rem [QB];
    logic [QB-1:0] r_low [QB];
    logic [QB-1:0] r_q   [QB];
    logic [DW-1:0] r_den [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QB-1:0] low_in;
        logic [QB-1:0] q_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign rem_in = i_num[NW-1:QB];
            assign low_in = i_num[QB-1:0];
            assign q_in   = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
            assign den_in = r_den[k-1];
        end

        always_comb begin
            trial = {rem_in, low_in[QB-1]};
            ge    = (trial >= {1'b0, den_in});
            n_rem = ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= low_in << 1;
                r_q[k]   <= {q_in[QB-2:0], ge};
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_q[QB-1];

endmodule

>>> src/cpr_lane.sv
module cpr_lane #(
    parameter int L = 21,
    parameter int F = 10
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [L-1:0]               i_pa,
    input  logic [L-1:0]               i_pb,
    input  logic [L-1:0]               i_va,
    input  logic [L-1:0]               i_vb,
    input  logic [L-1:0]               i_n,
    input  logic [cpr_pkg::IM_W-1:0]   i_ima,
    input  logic [cpr_pkg::IM_W-1:0]   i_imb,
    input  logic                       i_hb,
    input  logic [cpr_pkg::SCL_W-1:0]  i_vs,
    input  logic [cpr_pkg::SCL_W-1:0]  i_pen,
    output logic [L-1:0]               o_pa,
    output logic [L-1:0]               o_pb,
    output logic [L-1:0]               o_va,
    output logic [L-1:0]               o_vb,
    output logic                       o_sat
);
    import cpr_pkg::*;

    localparam int PW = L + SCL_W;
    localparam int MW = PW - 1;
    localparam int QB = L + SCL_W - 1 - F;
    localparam int NW = MW + IM_W + 1;
    localparam int DW = IM_W + 1 + F;
    localparam int VW = PW + IM_W + 1;
    localparam int WW = VW + 2;
    localparam int VSH = F + IM_FRAC;
    localparam int SW = 4 * L + 3;

    localparam logic signed [WW-1:0] HI = WW'((64'(1) << (L - 1)) - 64'(1));
    localparam logic signed [WW-1:0] LO = -HI - WW'(1);

    function automatic logic [L:0] clamp(input logic signed [WW-1:0] v);
        logic [L:0] r;
        if (v > HI) begin
            r = {1'b1, HI[L-1:0]};
        end else if (v < LO) begin
            r = {1'b1, LO[L-1:0]};
        end else begin
            r = {1'b0, v[L-1:0]};
        end
        return r;
    endfunction

    // Stage 1: normal times closing speed and penetration
    logic signed [PW-1:0] r1_nv, r1_np;
    logic [L-1:0]         r1_pa, r1_pb, r1_va, r1_vb;
    logic [IM_W-1:0]      r1_ima, r1_imb;
    logic                 r1_hb, r1_vneg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_nv   <= PW'($signed(i_n)) * PW'($signed(i_vs));
            r1_np   <= PW'($signed(i_n)) * PW'($signed(i_pen));
            r1_pa   <= i_pa;
            r1_pb   <= i_pb;
            r1_va   <= i_va;
            r1_vb   <= i_vb;
            r1_ima  <= i_ima;
            r1_imb  <= i_imb;
            r1_hb   <= i_hb;
            r1_vneg <= i_vs[SCL_W-1];
        end
    end

    // Stage 2: scale by inverse masses
    logic [MW-1:0]        np_mag;
    logic signed [VW-1:0] r2_pva, r2_pvb;
    logic [MW-1:0]        r2_full;
    logic [NW-1:0]        r2_na, r2_nb;
    logic [DW-1:0]        r2_den;
    logic                 r2_psign;
    logic [L-1:0]         r2_pa, r2_pb, r2_va, r2_vb;
    logic [IM_W-1:0]      r2_ima, r2_imb;
    logic                 r2_hb, r2_vneg;

    assign np_mag = r1_np[PW-1] ? MW'(-r1_np) : MW'(r1_np);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pva   <= VW'(r1_nv) * VW'($signed({1'b0, r1_ima}));
            r2_pvb   <= VW'(r1_nv) * VW'($signed({1'b0, r1_imb}));
            r2_full  <= MW'((np_mag + (MW'(1) << (F - 1))) >> F);
            r2_na    <= NW'(np_mag) * NW'(r1_ima);
            r2_nb    <= NW'(np_mag) * NW'(r1_imb);
            r2_den   <= DW'({1'b0, r1_ima} + {1'b0, r1_imb}) << F;
            r2_psign <= r1_np[PW-1];
            r2_pa    <= r1_pa;
            r2_pb    <= r1_pb;
            r2_va    <= r1_va;
            r2_vb    <= r1_vb;
            r2_ima   <= r1_ima;
            r2_imb   <= r1_imb;
            r2_hb    <= r1_hb;
            r2_vneg  <= r1_vneg;
        end
    end

    // Stage 3: round velocity change, apply one-sided push, start split divide
    logic                 ima_nz, imb_nz, case_a, case_b, case_s;
    logic [VW-1:0]        mva, mvb;
    logic signed [WW-1:0] dva, dvb, push;
    logic [L:0]           cva, cvb, cpa, cpb;
    logic [L-1:0]         s3_pa, s3_pb, s3_va, s3_vb;
    logic                 s3_sat;
    logic [NW-1:0]        num_a, num_b;

    always_comb begin
        ima_nz = (r2_ima != '0);
        imb_nz = (r2_imb != '0);
        case_a = ima_nz && (!r2_hb || !imb_nz);
        case_b = r2_hb && !ima_nz && imb_nz;
        case_s = r2_hb && ima_nz && imb_nz;

        mva = r2_pva[VW-1] ? VW'(-r2_pva) : VW'(r2_pva);
        mvb = r2_pvb[VW-1] ? VW'(-r2_pvb) : VW'(r2_pvb);
        dva = WW'((mva + (VW'(1) << (VSH - 1))) >> VSH);
        dvb = WW'((mvb + (VW'(1) << (VSH - 1))) >> VSH);
        if (r2_pva[VW-1]) dva = -dva;
        if (r2_pvb[VW-1]) dvb = -dvb;

        push = WW'(r2_full);
        if (r2_psign) push = -push;

        cva = clamp(WW'($signed(r2_va)) - dva);
        cvb = clamp(WW'($signed(r2_vb)) + dvb);
        cpa = clamp(WW'($signed(r2_pa)) + push);
        cpb = clamp(WW'($signed(r2_pb)) - push);

        s3_sat = 1'b0;
        s3_va  = r2_va;
        s3_vb  = r2_vb;
        if (r2_vneg) begin
            if (ima_nz) begin
                s3_va  = cva[L-1:0];
                s3_sat = cva[L];
            end else begin
                s3_va = '0;
            end
            if (r2_hb) begin
                if (imb_nz) begin
                    s3_vb  = cvb[L-1:0];
                    s3_sat = s3_sat | cvb[L];
                end else begin
                    s3_vb = '0;
                end
            end
        end

        s3_pa = r2_pa;
        s3_pb = r2_pb;
        if (case_a) begin
            s3_pa  = cpa[L-1:0];
            s3_sat = s3_sat | cpa[L];
        end
        if (case_b) begin
            s3_pb  = cpb[L-1:0];
            s3_sat = s3_sat | cpb[L];
        end

        num_a = r2_na + NW'(r2_den >> 1);
        num_b = r2_nb + NW'(r2_den >> 1);
    end

    logic [QB-1:0] qa, qb;

    cpr_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (num_a),
        .i_den (r2_den),
        .o_quo (qa)
    );

    cpr_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_b (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (num_b),
        .i_den (r2_den),
        .o_quo (qb)
    );

    // Delay line that rides along with the divider
    logic [SW-1:0] r_side [QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= {case_s, r2_psign, s3_sat, s3_vb, s3_va, s3_pb, s3_pa};
            for (int k = 1; k < QB; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Final: apply the split push
    logic [L-1:0]         d_pa, d_pb;
    logic                 d_case_s, d_psign, d_sat;
    logic signed [WW-1:0] sa, sb;
    logic [L:0]           fpa, fpb;

    always_comb begin
        {d_case_s, d_psign, d_sat, o_vb, o_va, d_pb, d_pa} = r_side[QB-1];
        sa = WW'(qa);
        sb = WW'(qb);
        if (d_psign) begin
            sa = -sa;
            sb = -sb;
        end
        fpa = clamp(WW'($signed(d_pa)) + sa);
        fpb = clamp(WW'($signed(d_pb)) - sb);
        if (d_case_s) begin
            o_pa  = fpa[L-1:0];
            o_pb  = fpb[L-1:0];
            o_sat = d_sat | fpa[L] | fpb[L];
        end else begin
            o_pa  = d_pa;
            o_pb  = d_pb;
            o_sat = d_sat;
        end
    end

endmodule

>>> src/particle_contact_resolver.sv
// Particle contact resolver: one contact per transaction, three axis lanes in parallel.
// Input to output: two multiply stages, one divider stage per quotient bit, then the output buffer.
// Throughput: one contact per cycle while the output buffer has room;
//   the split-push dividers are fully pipelined.
// Reset (i_rst_n low, synchronous) empties the pipeline and the two-entry output buffer.
module particle_contact_resolver #(
    parameter int LANE_BITS = cpr_pkg::LANE_BITS_DEF,
    parameter int FRAC_BITS = cpr_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: pos_a, pos_b, vel_a, vel_b, contact_normal, inv_mass_a, inv_mass_b,
    //        closing_speed, penetration_depth, zero pad
    input  logic [cpr_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: has_b
    input  logic [0:0]                    i_s_tuser,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: new_pos_a, new_pos_b, new_vel_a, new_vel_b, zero pad
    output logic [cpr_pkg::M_TDATA_W-1:0] o_m_tdata,
    // tuser: saturated
    output logic [0:0]                    o_m_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready
);
    import cpr_pkg::*;

    localparam int L   = LANE_BITS;
    localparam int LAT = 2 + L + SCL_W - 1 - FRAC_BITS;

    // Unpack the input transaction
    logic [VEC_W-1:0] pos_a, pos_b, vel_a, vel_b, nrm;
    logic [IM_W-1:0]  ima, imb;
    logic [SCL_W-1:0] vs, pen;

    assign pos_a = i_s_tdata[S_POS_A_LSB +: VEC_W];
    assign pos_b = i_s_tdata[S_POS_B_LSB +: VEC_W];
    assign vel_a = i_s_tdata[S_VEL_A_LSB +: VEC_W];
    assign vel_b = i_s_tdata[S_VEL_B_LSB +: VEC_W];
    assign nrm   = i_s_tdata[S_NORM_LSB  +: VEC_W];
    assign ima   = i_s_tdata[S_IMA_LSB   +: IM_W];
    assign imb   = i_s_tdata[S_IMB_LSB   +: IM_W];
    assign vs    = i_s_tdata[S_CS_LSB    +: SCL_W];
    assign pen   = i_s_tdata[S_PEN_LSB   +: SCL_W];

    // Advance the whole datapath while the output buffer has room
    logic [1:0] r_cnt;
    logic       en;
    logic       acc;

    assign en         = (r_cnt != 2'd2);
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;

    // Valid bits running alongside the lane pipelines
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], acc};
        end
    end

    // One lane per axis
    logic [L-1:0] l_pa [NUM_LANES];
    logic [L-1:0] l_pb [NUM_LANES];
    logic [L-1:0] l_va [NUM_LANES];
    logic [L-1:0] l_vb [NUM_LANES];
    logic         l_sat [NUM_LANES];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        cpr_lane #(.L(L), .F(FRAC_BITS)) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_pa  (pos_a[i*L +: L]),
            .i_pb  (pos_b[i*L +: L]),
            .i_va  (vel_a[i*L +: L]),
            .i_vb  (vel_b[i*L +: L]),
            .i_n   (nrm[i*L +: L]),
            .i_ima (ima),
            .i_imb (imb),
            .i_hb  (i_s_tuser[0]),
            .i_vs  (vs),
            .i_pen (pen),
            .o_pa  (l_pa[i]),
            .o_pb  (l_pb[i]),
            .o_va  (l_va[i]),
            .o_vb  (l_vb[i]),
            .o_sat (l_sat[i])
        );
    end

    // Merge: repack lanes x,y,z from the low end, zero the unused top bits, OR the clamp flags
    t_result mrg;

    always_comb begin
        mrg.pos_a = VEC_W'({l_pa[2], l_pa[1], l_pa[0]});
        mrg.pos_b = VEC_W'({l_pb[2], l_pb[1], l_pb[0]});
        mrg.vel_a = VEC_W'({l_va[2], l_va[1], l_va[0]});
        mrg.vel_b = VEC_W'({l_vb[2], l_vb[1], l_vb[0]});
        mrg.sat   = l_sat[0] | l_sat[1] | l_sat[2];
    end

    // Two-entry output buffer: keeps taking contacts while a result waits
    t_result r_buf [2];
    logic    r_wp, r_rp;
    logic    push, pop;

    assign push = en && r_vld[LAT-1];
    assign pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= mrg;
        end
    end

    t_result head;

    assign head       = r_buf[r_rp];
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = M_TDATA_W'({head.vel_b, head.vel_a, head.pos_b, head.pos_a});
    assign o_m_tuser  = head.sat;

endmodule

>>> src/cpr_checker.sv
module cpr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic [cpr_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [0:0]                    o_m_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready
);
    import cpr_pkg::*;

    // Output pipe is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // An empty output side never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // Pad bits above the four result vectors stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[M_TDATA_W-1:M_USED_W] == '0))
        else $error("nonzero pad bits in result");

    // Stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind particle_contact_resolver cpr_checker u_cpr_checker (.*);
